>>> rtl/core/stbs_pkg.sv
// Package for the sorted-table binary search block.
// Holds field widths, operation codes and the controller/datapath interface types.
// No dependencies.
package stbs_pkg;

    localparam int LEN_W = 11;  // table length register
    localparam int IDX_W = 10;  // entry index and position fields
    localparam int VAL_W = 16;  // entry value and search key

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr_entry;   // store the input entry
        logic init;       // latch key, set up bounds
        logic rd_issue;   // compute middle, read table
        logic step;       // compare and narrow bounds
        logic out_load;   // move result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic len_zero;   // table is empty
        logic finish;     // search ends on the current compare
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

>>> rtl/core/stbs_ctrl.sv
// Controller of the sorted-table binary search block.
// Sequences write, read and compare steps; depends on stbs_pkg.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_WRITE) begin
                        o_cmd.wr_entry = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        // empty table answers position 0, not found
                        n_state = i_sts.len_zero ? S_DONE : S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_CMP;
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.finish ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/stbs_dpath.sv
// Datapath of the sorted-table binary search block: table memory, length
// register, search bounds, compare and output register. Depends on stbs_pkg.
module stbs_dpath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_wr,
    input  logic [LEN_W-1:0]        i_cfg_data,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [VAL_W-1:0] i_entry_value,
    input  logic signed [VAL_W-1:0] i_search_key,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_position,
    output logic                    o_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;

    logic signed [VAL_W-1:0] r_table [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;
    logic signed [VAL_W-1:0] r_key;
    logic [LEN_W-1:0]        r_len;
    logic [AW-1:0]           r_bot;
    logic [AW-1:0]           r_top;
    logic [AW-1:0]           r_mid;
    logic                    r_hit;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_pos;
    logic                    r_out_found;

    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_clamp;
    logic [CW-1:0] len_m1;
    logic [IW-1:0] idx_ext;
    logic          wr_in_range;
    logic [AW:0]   bound_sum;
    logic [AW-1:0] mid_next;
    logic [IW-1:0] pos_ext;
    logic          key_eq;
    logic          key_above;

    // clamp length to the table depth
    assign len_ext   = CW'(r_len);
    assign len_clamp = (len_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : len_ext;
    assign len_m1    = len_clamp - CW'(1);

    assign idx_ext     = IW'(i_entry_index);
    assign wr_in_range = ({1'b0, idx_ext} < (IW + 1)'(TABLE_DEPTH));

    assign bound_sum = {1'b0, r_bot} + {1'b0, r_top};
    assign mid_next  = bound_sum[AW:1];

    assign key_eq    = (r_rd_data == r_key);
    assign key_above = (r_rd_data < r_key);

    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.finish   = !(r_bot < r_top) || key_eq;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry && wr_in_range) begin
            r_table[idx_ext[AW-1:0]] <= i_entry_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_table[mid_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_wr) begin
            r_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_key <= i_search_key;
            r_bot <= '0;
            r_top <= len_m1[AW-1:0];
            r_mid <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_mid <= mid_next;
        end else if (i_cmd.step) begin
            r_hit <= key_eq;
            if (!o_sts.finish) begin
                if (key_above) begin
                    r_bot <= r_mid + AW'(1);
                end else begin
                    r_top <= r_mid;
                end
            end
        end
    end

    assign pos_ext = IW'(r_mid);

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos   <= pos_ext[IDX_W-1:0];
            r_out_found <= r_hit;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_found    = r_out_found;

endmodule

>>> rtl/core/sorted_table_binary_search.sv
// Sorted-table binary search, top level. Uses stbs_ctrl, stbs_dpath, stbs_pkg.
// Write item: taken without stalling, no result; the next item can follow at once.
// Search item: each halving step is a table read then a compare, at most
// ceil(log2(length)) + 1 steps, then the result moves to the output register
// once it is free; an empty table skips the steps. No new item is taken until then.
// Synchronous active-low reset clears control and length; table is not cleared.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LEN_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_op,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [VAL_W-1:0] i_entry_value,
    input  logic signed [VAL_W-1:0] i_search_key,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [IDX_W-1:0]        o_position,
    output logic                    o_found
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_position    (o_position),
        .o_found       (o_found)
    );

endmodule

>>> rtl/core/stbs_checker.sv
// Port-level checker for the sorted-table binary search block and its bind.
// Depends on stbs_pkg; watches only the top-level ports.
module stbs_checker
    import stbs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_op,
    input logic             o_valid,
    input logic             i_stall,
    input logic [IDX_W-1:0] o_position,
    input logic             o_found
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_position) && $stable(o_found))
        else $error("result changed while stalled");

    // a search transfer makes the block busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_SEARCH) |=> o_stall)
        else $error("search transfer did not start work");

    // a write transfer leaves the input open
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_WRITE) |=> !o_stall)
        else $error("write transfer blocked the input");

    // a new result only comes out of a search in progress
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
